@@ sv/sha_pkg.sv @@
// SHA-256 hasher package: state enum, round constants, initial hash values
// and the round helper functions. No dependencies.
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_t;

  // One byte position of the block buffer is 6 bits.
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam logic [7:0]  PadByte    = 8'h80;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ sv/sha_round.sv @@
// SHA-256 round unit: one compression round on the working variables,
// plus the message schedule word for that round. Uses sha_pkg.
module sha_round import sha_pkg::*; (
  input  logic [31:0] vin [8],
  input  logic [31:0] win [16],
  input  logic [5:0]  t,
  output logic [31:0] vout [8],
  output logic [31:0] wt
);
  logic [31:0] x2, x15, s0, s1, big0, big1, chv, mj, t1, t2;

  // Form the schedule word: direct for the first 16 rounds, expanded after
  always_comb begin
    x2  = win[4'(t - 6'd2)];
    x15 = win[4'(t - 6'd15)];
    s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    if (t < 6'd16) begin
      wt = win[t[3:0]];
    end else begin
      wt = s1 + win[4'(t - 6'd7)] + s0 + win[t[3:0]];
    end
  end

  // Apply one round
  always_comb begin
    big1 = rotr(vin[4], 6) ^ rotr(vin[4], 11) ^ rotr(vin[4], 25);
    chv  = (vin[4] & vin[5]) ^ (~vin[4] & vin[6]);
    t1   = vin[7] + big1 + chv + K[t] + wt;
    big0 = rotr(vin[0], 2) ^ rotr(vin[0], 13) ^ rotr(vin[0], 22);
    mj   = (vin[0] & vin[1]) ^ (vin[0] & vin[2]) ^ (vin[1] & vin[2]);
    t2   = big0 + mj;
    vout[7] = vin[6];
    vout[6] = vin[5];
    vout[5] = vin[4];
    vout[4] = vin[3] + t1;
    vout[3] = vin[2];
    vout[2] = vin[1];
    vout[1] = vin[0];
    vout[0] = t1 + t2;
  end
endmodule

@@ sv/sha256_message_hasher.sv @@
// SHA-256 message hasher top level: byte intake, padding sequencer,
// compression control and digest output. Uses sha_pkg and sha_round.
//
// Bytes enter one per transfer. The 64th byte of a block starts the shared
// round unit. The unit runs one round per cycle, so s_tready stays low
// through the rounds and the chaining add. An end-of-message transfer then
// feeds the padding bytes through the same path at one per cycle. That is
// the 0x80 byte, zero fill and the 8-byte length: from 9 up to 72 bytes,
// with one compression per block that it fills. The block then emits the
// eight digest words on the output stream, H0 first, the last one with
// tlast. Each word waits for m_tready. The next message is taken once the
// last word has been transferred.
module sha256_message_hasher import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] msg_byte
  input  logic [1:0]  s_tuser,   // [0] has_byte, [1] end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_tlast    // last_word
);
  state_t      state, state_next;
  logic [31:0] chain [8];
  logic [31:0] vars [8];
  logic [31:0] vnew [8];
  logic [31:0] win [16];
  logic [31:0] wt;
  logic [5:0]  pos;
  logic [60:0] total;
  logic [5:0]  rnd;
  logic [2:0]  widx;
  logic        pad_mode;   // padding after compression
  logic        len_phase;  // 0x80 byte written, zero fill or length follows
  logic        len_ok;     // current block has room for the length
  logic        len_done;   // length written, last block is compressing
  logic        accept;
  logic        put_en;
  logic [7:0]  put_byte;
  logic [63:0] bits;

  sha_round u_round (.vin(vars), .win(win), .t(rnd), .vout(vnew), .wt(wt));

  assign accept = s_tvalid && s_tready;
  assign bits   = {total, 3'b000};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser[0] && pos == 6'd63) state_next = ST_ROUND;
          else if (s_tuser[1]) state_next = ST_PAD;
        end
      end
      ST_ROUND: if (rnd == 6'd63) state_next = ST_ADD;
      ST_ADD: begin
        if (len_done) state_next = ST_EMIT;
        else if (pad_mode) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_PAD:   if (pos == 6'd63) state_next = ST_ROUND;
      ST_EMIT:  if (m_tready && widx == 3'd7) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Byte to write into the block buffer
  always_comb begin
    put_en   = 1'b0;
    put_byte = s_tdata;
    if (state == ST_IDLE && accept && s_tuser[0]) begin
      put_en = 1'b1;
    end else if (state == ST_PAD) begin
      put_en = 1'b1;
      if (!len_phase) put_byte = PadByte;
      else if (len_ok && pos >= 6'(LenPos)) put_byte = bits[{~pos[2:0], 3'b000} +: 8];
      else put_byte = 8'h00;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT);
  assign m_tdata  = {5'd0, widx, chain[widx]};
  assign m_tlast  = (widx == 3'd7);

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      total     <= '0;
      rnd       <= '0;
      widx      <= '0;
      pad_mode  <= 1'b0;
      len_phase <= 1'b0;
      len_ok    <= 1'b0;
      len_done  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= IV[i];
        vars[i]  <= '0;
      end
    end else begin
      state <= state_next;
      if (put_en) pos <= pos + 6'd1;
      if (state == ST_IDLE && accept) begin
        if (s_tuser[0]) total <= total + 61'd1;
        if (s_tuser[1]) pad_mode <= 1'b1;
      end
      // Padding: 0x80 first, then zeros, then the length once a block has room
      if (state == ST_PAD) begin
        len_phase <= 1'b1;
        if (!len_phase && pos < 6'(LenPos)) len_ok <= 1'b1;
        if (len_phase && len_ok && pos == 6'd63) len_done <= 1'b1;
      end
      if (state == ST_ROUND) rnd <= rnd + 6'd1;
      if (state_next == ST_ROUND && state != ST_ROUND) begin
        rnd <= '0;
        for (int i = 0; i < 8; i++) vars[i] <= chain[i];
      end else if (state == ST_ROUND) begin
        for (int i = 0; i < 8; i++) vars[i] <= vnew[i];
      end
      if (state == ST_ADD) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + vars[i];
        // A fresh padding block always has room for the length
        if (pad_mode) len_ok <= 1'b1;
      end
      if (state == ST_EMIT && m_tready) begin
        widx <= widx + 3'd1;
        if (widx == 3'd7) begin
          for (int i = 0; i < 8; i++) chain[i] <= IV[i];
          total     <= '0;
          pad_mode  <= 1'b0;
          len_phase <= 1'b0;
          len_ok    <= 1'b0;
          len_done  <= 1'b0;
        end
      end
    end
  end

  // Block buffer: byte writes, schedule expansion during rounds
  always_ff @(posedge clk) begin
    if (put_en) begin
      win[pos[5:2]][8*(3-pos[1:0]) +: 8] <= put_byte;
    end else if (state == ST_ROUND && rnd >= 6'd16) begin
      win[rnd[3:0]] <= wt;
    end
  end

  property p_ready_idle;
    @(posedge clk) disable iff (rst) (state == ST_ROUND) |-> !s_tready;
  endproperty
  a_ready_idle: assert property (p_ready_idle) else $error("ready during rounds");

  property p_no_overlap;
    @(posedge clk) disable iff (rst) !(s_tready && m_tvalid);
  endproperty
  a_no_overlap: assert property (p_no_overlap) else $error("intake during output");

  property p_last_wraps;
    @(posedge clk) disable iff (rst) (m_tvalid && m_tready && m_tlast) |=> !m_tvalid;
  endproperty
  a_last_wraps: assert property (p_last_wraps) else $error("output after last word");
endmodule
